FILE: rtl/x86_prefix_decoder_defines.svh
// Assertion macros for the x86 prefix decoder.
// Used by the top level; no other dependencies.
`ifndef X86_PREFIX_DECODER_DEFINES_SVH
`define X86_PREFIX_DECODER_DEFINES_SVH

// a holds -> c holds in the same cycle
`define XPD_ASSERT_SAME(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("xpd: same-cycle check failed");

// a holds -> c holds in the next cycle
`define XPD_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("xpd: next-cycle check failed");

`endif

FILE: rtl/xpd_pkg.sv
// Package for the x86 prefix decoder: prefix byte codes, field codes,
// and the prefix state struct. No dependencies.
`default_nettype none
package xpd_pkg;

  localparam logic [7:0] BYTE_REP_MATCH  = 8'hF2;
  localparam logic [7:0] BYTE_PAIR_MASK  = 8'hFE;
  localparam logic [7:0] BYTE_ADDR_SIZE  = 8'h67;
  localparam logic [7:0] BYTE_OPND_SIZE  = 8'h66;
  localparam logic [7:0] BYTE_SEG_MASK   = 8'hE7;
  localparam logic [7:0] BYTE_SEG_MATCH  = 8'h26;
  localparam logic [7:0] BYTE_FS         = 8'h64;
  localparam logic [7:0] BYTE_LOCK       = 8'hF0;

  localparam logic [1:0] REP_NONE = 2'd0;
  localparam logic [1:0] REP_NZ   = 2'd1;
  localparam logic [1:0] REP_Z    = 2'd2;

  localparam logic [2:0] SEG_FS   = 3'd4;
  localparam logic [2:0] SEG_GS   = 3'd5;
  localparam logic [2:0] SEG_NONE = 3'd6;

  localparam logic [3:0] COUNT_MAX = 4'd15;

  localparam logic DEFAULT_SIZE_RESET = 1'b0;

  typedef struct packed {
    logic [1:0] rep;
    logic [2:0] seg;
    logic       addr32;
    logic       opnd32;
    logic       lock;
    logic [3:0] count;
  } pfx_state_t;

endpackage
`default_nettype wire

FILE: rtl/xpd_byte_if.sv
// Request channels of the x86 prefix decoder: code bytes in, results out.
// Depends on nothing but the handshake convention valid/ready.
`default_nettype none
interface xpd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_byte;

  modport source (output valid, output code_byte, input ready);
  modport sink   (input valid, input code_byte, output ready);
endinterface

interface xpd_result_if;
  logic       valid;
  logic       ready;
  logic       is_prefix;
  logic [7:0] opcode;
  logic [1:0] rep_mode;
  logic [2:0] segment_select;
  logic       address_32;
  logic       operand_32;
  logic       lock_seen;
  logic [3:0] prefix_count;

  modport source (output valid, output is_prefix, output opcode, output rep_mode,
                  output segment_select, output address_32, output operand_32,
                  output lock_seen, output prefix_count, input ready);
  modport sink   (input valid, input is_prefix, input opcode, input rep_mode,
                  input segment_select, input address_32, input operand_32,
                  input lock_seen, input prefix_count, output ready);
endinterface
`default_nettype wire

FILE: rtl/x86_prefix_decoder.sv
// x86 prefix decoder, top level.
//
// in_ch  : code bytes, one request per byte, valid/ready.
// out_ch : one result request per byte: is_prefix, the opcode (0 for a
//          prefix) and the prefix state (repeat mode, segment, address and
//          operand size, lock, prefix count saturating at 15).
// cfg_wr_en / cfg_wr_data : writes default_size_32; write only when idle.
//
// A byte goes into an input register, is decoded against the prefix state
// and its result lands in the output register. One byte per cycle is
// sustained while out_ch takes each result; the prefix state update is a
// loop from the state register through the combinational decoder.
// Reset (synchronous, rst_n low) clears both stages, sets default_size_32
// to 0 and loads the default prefix state. When out_ch stalls, the result
// holds, the input stage keeps its byte and in_ch ready drops once both
// stages are full.
// Depends on xpd_pkg, xpd_byte_if, xpd_result_if, xpd_decode and
// x86_prefix_decoder_defines.svh.
`default_nettype none
`include "x86_prefix_decoder_defines.svh"
module x86_prefix_decoder (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     cfg_wr_en,
  input  wire logic     cfg_wr_data,
  xpd_byte_if.sink      in_ch,
  xpd_result_if.source  out_ch
);
  import xpd_pkg::*;

  logic       dflt_size_r;
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  pfx_state_t state_r;
  pfx_state_t state_nxt;
  pfx_state_t shown;
  logic       dec_is_prefix;
  logic       out_valid_r;
  logic       out_is_prefix_r;
  logic [7:0] out_opcode_r;
  pfx_state_t out_state_r;
  logic       advance;

  xpd_decode u_decode (
    .code_byte       (s1_byte_r),
    .default_size_32 (dflt_size_r),
    .cur             (state_r),
    .is_prefix       (dec_is_prefix),
    .shown           (shown),
    .nxt             (state_nxt)
  );

  assign advance     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dflt_size_r    <= DEFAULT_SIZE_RESET;
      s1_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      state_r.rep    <= REP_NONE;
      state_r.seg    <= SEG_NONE;
      state_r.addr32 <= DEFAULT_SIZE_RESET;
      state_r.opnd32 <= DEFAULT_SIZE_RESET;
      state_r.lock   <= 1'b0;
      state_r.count  <= '0;
    end else begin
      if (cfg_wr_en) begin
        dflt_size_r <= cfg_wr_data;
        if (state_r.count == '0) begin
          state_r.addr32 <= cfg_wr_data;
          state_r.opnd32 <= cfg_wr_data;
        end
      end
      if (in_ch.ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (advance) begin
        state_r     <= state_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_byte_r <= in_ch.code_byte;
    end
    if (advance) begin
      out_is_prefix_r <= dec_is_prefix;
      out_opcode_r    <= dec_is_prefix ? 8'h00 : s1_byte_r;
      out_state_r     <= shown;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.is_prefix      = out_is_prefix_r;
  assign out_ch.opcode         = out_opcode_r;
  assign out_ch.rep_mode       = out_state_r.rep;
  assign out_ch.segment_select = out_state_r.seg;
  assign out_ch.address_32     = out_state_r.addr32;
  assign out_ch.operand_32     = out_state_r.opnd32;
  assign out_ch.lock_seen      = out_state_r.lock;
  assign out_ch.prefix_count   = out_state_r.count;

  `XPD_ASSERT_SAME(a_prefix_has_count, clk, rst_n,
    out_valid_r && out_is_prefix_r, out_state_r.count != '0 && out_opcode_r == 8'h00)
  `XPD_ASSERT_SAME(a_codes_legal, clk, rst_n,
    out_valid_r, out_state_r.rep != 2'd3 && out_state_r.seg != 3'd7)
  `XPD_ASSERT_NEXT(a_stage_held, clk, rst_n,
    s1_valid_r && out_valid_r && !out_ch.ready, s1_valid_r && $stable(s1_byte_r))
  `XPD_ASSERT_NEXT(a_opcode_resets_state, clk, rst_n,
    advance && !dec_is_prefix, state_r.count == '0 && state_r.lock == 1'b0)

endmodule
`default_nettype wire

FILE: rtl/xpd_decode.sv
// Combinational prefix decode: classifies one byte, computes the result
// state and the next prefix state. Depends on xpd_pkg.
`default_nettype none
module xpd_decode (
  input  wire logic [7:0]         code_byte,
  input  wire logic               default_size_32,
  input  wire xpd_pkg::pfx_state_t cur,
  output logic                    is_prefix,
  output xpd_pkg::pfx_state_t     shown,
  output xpd_pkg::pfx_state_t     nxt
);
  import xpd_pkg::*;

  pfx_state_t upd;
  pfx_state_t dflt;

  always_comb begin
    upd       = cur;
    is_prefix = 1'b1;
    priority if ((code_byte & BYTE_PAIR_MASK) == BYTE_REP_MATCH) begin
      upd.rep = code_byte[0] ? REP_Z : REP_NZ;
    end else if (code_byte == BYTE_ADDR_SIZE) begin
      upd.addr32 = ~cur.addr32;
    end else if (code_byte == BYTE_OPND_SIZE) begin
      upd.opnd32 = ~cur.opnd32;
    end else if ((code_byte & BYTE_SEG_MASK) == BYTE_SEG_MATCH) begin
      upd.seg = {1'b0, code_byte[4:3]};
    end else if ((code_byte & BYTE_PAIR_MASK) == BYTE_FS) begin
      upd.seg = (code_byte == BYTE_FS) ? SEG_FS : SEG_GS;
    end else if (code_byte == BYTE_LOCK) begin
      upd.lock = 1'b1;
    end else begin
      is_prefix = 1'b0;
    end
    if (cur.count != COUNT_MAX) begin
      upd.count = cur.count + 4'd1;
    end
  end

  always_comb begin
    dflt.rep    = REP_NONE;
    dflt.seg    = SEG_NONE;
    dflt.addr32 = default_size_32;
    dflt.opnd32 = default_size_32;
    dflt.lock   = 1'b0;
    dflt.count  = '0;
  end

  assign shown = is_prefix ? upd : cur;
  assign nxt   = is_prefix ? upd : dflt;

endmodule
`default_nettype wire
